@@ rtl/bhoe_pkg.sv @@
package bhoe_pkg;

    // Field widths of the two channels
    localparam int TAG_W = 8;
    localparam int LEN_W = 31;
    localparam int ARC_FIELD_W = 31;

    // Widest value the serializer carries: arc up to 31 bits times 40 plus an arc
    localparam int VAL_W = 37;

    // Digit index width and digit limits
    localparam int DIG_W = 3;
    localparam int MAX_GROUPS = 6;
    localparam int LEN_BYTES = 4;

    // Opcodes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_ARC    = 1'b1;

    // Length form constants
    localparam logic [VAL_W-1:0] SHORT_MAX = VAL_W'(127);
    localparam logic [7:0]       LONG_FLAG = 8'h80;
    localparam logic [6:0]       SEVEN_MASK = 7'h7F;

    typedef struct packed {
        logic                   opcode;
        logic [TAG_W-1:0]       tag_byte;
        logic [LEN_W-1:0]       content_length;
        logic [ARC_FIELD_W-1:0] arc_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
    } t_out_item;

    // Command handed from the front to the serializer
    typedef struct packed {
        logic             is_arc;
        logic [TAG_W-1:0] tag;
        logic [VAL_W-1:0] val;
    } t_cmd;

endpackage

@@ rtl/bhoe_front.sv @@
module bhoe_front #(
    parameter int ARC_W = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bhoe_pkg::t_in_item  i_data,
    input  logic                i_q_full,
    output logic                o_push,
    output bhoe_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ARC_NONE = 2'd0;
    localparam logic [1:0] ARC_ONE  = 2'd1;
    localparam logic [1:0] ARC_MORE = 2'd2;

    logic [1:0]                     r_arc_count, n_arc_count;
    logic [ARC_W-1:0]               r_held, n_held;
    logic [ARC_W-1:0]               w_arc;
    logic [bhoe_pkg::VAL_W-1:0]     w_held_ext;
    logic [bhoe_pkg::VAL_W-1:0]     w_arc_ext;
    logic [bhoe_pkg::VAL_W-1:0]     w_combined;
    logic                           w_accept;

    // Take an item whenever the queue has room
    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    // Arc taken to its configured width; first*40+second as two shifted adds
    assign w_arc      = i_data.arc_value[ARC_W-1:0];
    assign w_held_ext = bhoe_pkg::VAL_W'(r_held);
    assign w_arc_ext  = bhoe_pkg::VAL_W'(w_arc);
    assign w_combined = (w_held_ext << 5) + (w_held_ext << 3) + w_arc_ext;

    // Classify the item and build the serializer command
    always_comb begin
        n_arc_count = r_arc_count;
        n_held      = r_held;
        o_push      = 1'b0;
        o_cmd.is_arc = i_data.opcode;
        o_cmd.tag    = i_data.tag_byte;
        o_cmd.val    = bhoe_pkg::VAL_W'(i_data.content_length);
        if (w_accept) begin
            if (i_data.opcode == bhoe_pkg::OP_HEADER) begin
                n_arc_count = ARC_NONE;
                o_push      = 1'b1;
            end else begin
                case (r_arc_count)
                    ARC_NONE: begin
                        // hold the first arc, emit nothing
                        n_held      = w_arc;
                        n_arc_count = ARC_ONE;
                    end
                    ARC_ONE: begin
                        n_arc_count = ARC_MORE;
                        o_cmd.val   = w_combined;
                        o_push      = 1'b1;
                    end
                    default: begin
                        o_cmd.val = w_arc_ext;
                        o_push    = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arc_count <= ARC_NONE;
            r_held      <= '0;
        end else begin
            r_arc_count <= n_arc_count;
            r_held      <= n_held;
        end
    end

endmodule

@@ rtl/bhoe_queue.sv @@
module bhoe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bhoe_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output bhoe_pkg::t_cmd  o_head,
    output logic            o_full,
    output logic            o_empty
);

    bhoe_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt, n_cnt;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    // Track fill level
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/bhoe_back.sv @@
module bhoe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bhoe_pkg::t_cmd      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output bhoe_pkg::t_out_item o_data
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TAG  = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DIG  = 2'd3;

    logic [1:0]                 r_ph, n_ph;
    logic                       r_seven, n_seven;
    logic                       r_short, n_short;
    logic [bhoe_pkg::DIG_W-1:0] r_dig, n_dig;
    logic [bhoe_pkg::VAL_W-1:0] r_val, n_val;
    logic [7:0]                 r_tag, n_tag;
    logic                       r_out_valid, n_out_valid;
    bhoe_pkg::t_out_item        r_out, n_out;

    logic                       w_busy;
    logic                       w_adv;
    logic [7:0]                 w_byte;
    logic                       w_last;
    logic [5:0]                 w_amt7;
    logic [bhoe_pkg::VAL_W-1:0] w_sh;
    logic [bhoe_pkg::DIG_W-1:0] w_groups_m1;
    logic [bhoe_pkg::DIG_W-1:0] w_octets_m1;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign w_busy = (r_ph != PH_IDLE);
    assign w_adv  = !r_out_valid || !i_stall;
    assign w_amt7 = {r_dig, 3'b000} - {3'b000, r_dig};

    // Count digits of the queue head: base-128 groups and length octets
    always_comb begin
        int g;
        w_groups_m1 = '0;
        w_octets_m1 = '0;
        for (g = 1; g < bhoe_pkg::MAX_GROUPS; g++) begin
            if ((i_head.val >> (7 * g)) != '0) begin
                w_groups_m1 = bhoe_pkg::DIG_W'(g);
            end
        end
        for (g = 1; g < bhoe_pkg::LEN_BYTES; g++) begin
            if ((i_head.val >> (8 * g)) != '0) begin
                w_octets_m1 = bhoe_pkg::DIG_W'(g);
            end
        end
    end

    // Select the current octet
    always_comb begin
        w_byte = '0;
        w_last = 1'b0;
        w_sh   = '0;
        case (r_ph)
            PH_TAG: begin
                w_byte = r_tag;
            end
            PH_LEN: begin
                if (r_short) begin
                    w_byte = r_val[7:0];
                    w_last = 1'b1;
                end else begin
                    w_byte = bhoe_pkg::LONG_FLAG | (8'(r_dig) + 8'd1);
                end
            end
            PH_DIG: begin
                if (r_seven) begin
                    w_sh   = r_val >> w_amt7;
                    w_byte = {(r_dig != '0), w_sh[6:0] & bhoe_pkg::SEVEN_MASK};
                end else begin
                    w_sh   = r_val >> {r_dig, 3'b000};
                    w_byte = w_sh[7:0];
                end
                w_last = (r_dig == '0);
            end
            default: begin
                w_byte = '0;
                w_last = 1'b0;
            end
        endcase
    end

    // Pop the next command when idle or as the current one finishes
    assign o_pop = !i_empty && (!w_busy || (w_adv && w_last));

    // Advance the sequence and load new commands
    always_comb begin
        n_ph        = r_ph;
        n_seven     = r_seven;
        n_short     = r_short;
        n_dig       = r_dig;
        n_val       = r_val;
        n_tag       = r_tag;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_adv) begin
            n_out_valid       = w_busy;
            n_out.out_byte     = w_byte;
            n_out.last_of_item = w_last;
        end
        if (w_busy && w_adv) begin
            case (r_ph)
                PH_TAG: begin
                    n_ph = PH_LEN;
                end
                PH_LEN: begin
                    n_ph = r_short ? PH_IDLE : PH_DIG;
                end
                PH_DIG: begin
                    if (r_dig == '0) begin
                        n_ph = PH_IDLE;
                    end else begin
                        n_dig = r_dig - bhoe_pkg::DIG_W'(1);
                    end
                end
                default: begin
                    n_ph = PH_IDLE;
                end
            endcase
        end
        if (o_pop) begin
            n_val = i_head.val;
            n_tag = i_head.tag;
            if (i_head.is_arc) begin
                n_ph    = PH_DIG;
                n_seven = 1'b1;
                n_short = 1'b0;
                n_dig   = w_groups_m1;
            end else begin
                n_ph    = PH_TAG;
                n_seven = 1'b0;
                n_short = (i_head.val <= bhoe_pkg::SHORT_MAX);
                n_dig   = w_octets_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_seven <= n_seven;
        r_short <= n_short;
        r_dig   <= n_dig;
        r_val   <= n_val;
        r_tag   <= n_tag;
        r_out   <= n_out;
    end

endmodule

@@ rtl/ber_header_and_oid_encoder_unit.sv @@
// BER header and OID arc encoder.
// Input channel (i_valid / o_stall, payload i_data): opcode 0 carries a tag
// byte and a content length, opcode 1 carries one object identifier arc.
// Output channel (o_valid / i_stall, payload o_data): one encoded octet per
// item, with last_of_item set on the final octet caused by an input item.
// A header yields the tag, then a short-form length (2 octets total) or a
// long-form length (3 to 6 octets total). The first arc after a header
// yields nothing and is held; the second yields first*40+second in base 128
// (1 to 6 octets); later arcs yield their own base-128 digits (1 to 5 octets).
// An accepted item passes through the command queue, then the serializer's
// phase registers and its output register. Throughput: one octet per cycle
// while the receiver does not stall; the output port sets that rate.
// A two-entry command queue lets new items be accepted while earlier
// octets are still being sent. When the receiver stalls, the output octet
// holds and the queue fills, after which o_stall rises.
// Reset clears the arc counter, the held arc, the queue and the serializer.
module ber_header_and_oid_encoder_unit #(
    parameter int ARC_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bhoe_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output bhoe_pkg::t_out_item o_data
);

    localparam int ARC_W = (ARC_BITS < bhoe_pkg::ARC_FIELD_W) ? ARC_BITS
                                                              : bhoe_pkg::ARC_FIELD_W;

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    bhoe_pkg::t_cmd w_cmd;
    bhoe_pkg::t_cmd w_head;

    bhoe_front #(
        .ARC_W (ARC_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    bhoe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    bhoe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    bhoe_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    bhoe_pkg::t_out_item o_data;

    // Octets still owed by the block, oldest first
    bhoe_pkg::t_out_item octets_due[$];

    // Predictor state: arcs seen since the last header, and the held first arc
    logic [1:0]                       arcs_seen;
    logic [bhoe_pkg::ARC_FIELD_W-1:0] first_arc;

    // Idling on both channels is enabled while this is set
    bit idle_on;

    int errors = 0;
    int n_items;
    int n_headers;
    int n_arcs;
    int n_octets = 0;
    bhoe_pkg::t_out_item got_due;

    ber_header_and_oid_encoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock: 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Append one expected octet
    function automatic void queue_octet(input logic [7:0] b, input logic last);
        bhoe_pkg::t_out_item o;
        o.out_byte = b;
        o.last_of_item = last;
        octets_due.push_back(o);
    endfunction

    // Append the base-128 digits of a value, most significant group first
    function automatic void queue_arc_digits(input logic [bhoe_pkg::VAL_W-1:0] v);
        int groups;
        int g;
        logic [bhoe_pkg::VAL_W-1:0] t;
        groups = 1;
        t = v >> 7;
        while (t != 0 && groups < bhoe_pkg::MAX_GROUPS) begin
            groups++;
            t = t >> 7;
        end
        for (g = groups - 1; g >= 0; g--) begin
            if (g > 0) begin
                queue_octet({1'b1, 7'(v >> (7 * g))}, 1'b0);
            end else begin
                queue_octet({1'b0, 7'(v)}, 1'b1);
            end
        end
    endfunction

    // Work out the octets an accepted item causes and advance the arc state
    function automatic void encode_item(input bhoe_pkg::t_in_item it);
        int n;
        int i;
        logic [bhoe_pkg::LEN_W-1:0] t;
        logic [bhoe_pkg::VAL_W-1:0] combined;
        if (it.opcode == bhoe_pkg::OP_HEADER) begin
            arcs_seen = 2'd0;
            queue_octet(it.tag_byte, 1'b0);
            if (it.content_length <= bhoe_pkg::LEN_W'(127)) begin
                queue_octet(it.content_length[7:0], 1'b1);
            end else begin
                n = 1;
                t = it.content_length >> 8;
                while (t != 0) begin
                    n++;
                    t = t >> 8;
                end
                queue_octet(bhoe_pkg::LONG_FLAG | 8'(n), 1'b0);
                for (i = n - 1; i >= 0; i--) begin
                    queue_octet(8'(it.content_length >> (8 * i)), i == 0);
                end
            end
        end else if (arcs_seen == 2'd0) begin
            first_arc = it.arc_value;
            arcs_seen = 2'd1;
        end else if (arcs_seen == 2'd1) begin
            arcs_seen = 2'd2;
            combined = bhoe_pkg::VAL_W'(first_arc) * bhoe_pkg::VAL_W'(40)
                     + bhoe_pkg::VAL_W'(it.arc_value);
            queue_arc_digits(combined);
        end else begin
            queue_arc_digits(bhoe_pkg::VAL_W'(it.arc_value));
        end
    endfunction

    function automatic bhoe_pkg::t_in_item make_header(input logic [7:0] tag,
                                                       input logic [bhoe_pkg::LEN_W-1:0] len);
        bhoe_pkg::t_in_item it;
        it.opcode = bhoe_pkg::OP_HEADER;
        it.tag_byte = tag;
        it.content_length = len;
        it.arc_value = bhoe_pkg::ARC_FIELD_W'($urandom);
        return it;
    endfunction

    function automatic bhoe_pkg::t_in_item make_arc(
        input logic [bhoe_pkg::ARC_FIELD_W-1:0] arc);
        bhoe_pkg::t_in_item it;
        it.opcode = bhoe_pkg::OP_ARC;
        it.tag_byte = 8'($urandom);
        it.content_length = bhoe_pkg::LEN_W'($urandom);
        it.arc_value = arc;
        return it;
    endfunction

    // Length spread over short form and every long-form octet count
    function automatic logic [bhoe_pkg::LEN_W-1:0] rand_length();
        if ($urandom_range(99) < 30) begin
            return bhoe_pkg::LEN_W'($urandom_range(127));
        end
        return bhoe_pkg::LEN_W'($urandom) >> $urandom_range(30);
    endfunction

    function automatic logic [bhoe_pkg::ARC_FIELD_W-1:0] rand_arc();
        return bhoe_pkg::ARC_FIELD_W'($urandom) >> $urandom_range(30);
    endfunction

    // Offer one item, hold it until accepted, then predict its octets
    task automatic send_item(input bhoe_pkg::t_in_item it);
        int gap;
        gap = 0;
        while (idle_on && gap < 8 && $urandom_range(99) < 33) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        encode_item(it);
        n_items++;
        if (it.opcode == bhoe_pkg::OP_HEADER) begin
            n_headers++;
        end else begin
            n_arcs++;
        end
    endtask

    // Arcs before any header: the first one is held as the first arc of an OID
    task automatic test_arcs_after_reset();
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(1)));
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(2)));
        send_item(make_arc({bhoe_pkg::ARC_FIELD_W{1'b1}}));
    endtask

    // Short form up to 127, then every long-form octet count and its edges
    task automatic test_headers();
        send_item(make_header(8'h00, bhoe_pkg::LEN_W'(0)));
        send_item(make_header(8'hFF, bhoe_pkg::LEN_W'(127)));
        send_item(make_header(8'h30, bhoe_pkg::LEN_W'(128)));
        send_item(make_header(8'h04, bhoe_pkg::LEN_W'(255)));
        send_item(make_header(8'h02, bhoe_pkg::LEN_W'(256)));
        send_item(make_header(8'hA5, bhoe_pkg::LEN_W'(32'h0000_FFFF)));
        send_item(make_header(8'h5A, bhoe_pkg::LEN_W'(32'h0001_0000)));
        send_item(make_header(8'h06, bhoe_pkg::LEN_W'(32'h00FF_FFFF)));
        send_item(make_header(8'h31, bhoe_pkg::LEN_W'(32'h0100_0000)));
        send_item(make_header(8'h80, {bhoe_pkg::LEN_W{1'b1}}));
    endtask

    // Widest combined value, digit boundaries, and a fresh OID after a header
    task automatic test_oid_edges();
        send_item(make_header(8'h06, bhoe_pkg::LEN_W'(9)));
        send_item(make_arc({bhoe_pkg::ARC_FIELD_W{1'b1}}));
        send_item(make_arc({bhoe_pkg::ARC_FIELD_W{1'b1}}));
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(0)));
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(127)));
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(128)));
        send_item(make_header(8'h06, bhoe_pkg::LEN_W'(3)));
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(2)));
        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'(0)));
    endtask

    // Mostly header-then-arcs streams with random content, some stray items
    task automatic test_random_streams();
        int k;
        int arcs;
        int j;
        k = 0;
        while (k < 150) begin
            idle_on = !(k >= 60 && k < 100);
            if ($urandom_range(9) < 8) begin
                send_item(make_header(8'($urandom), rand_length()));
                k++;
                arcs = $urandom_range(1, 6);
                for (j = 0; j < arcs; j++) begin
                    if (j == 0 && $urandom_range(3) != 0) begin
                        send_item(make_arc(bhoe_pkg::ARC_FIELD_W'($urandom_range(2))));
                    end else begin
                        send_item(make_arc(rand_arc()));
                    end
                    k++;
                end
            end else if ($urandom_range(1) == 0) begin
                send_item(make_arc(rand_arc()));
                k++;
            end else begin
                send_item(make_header(8'($urandom), rand_length()));
                k++;
            end
        end
        idle_on = 1'b1;
    endtask

    // Check each accepted octet against the oldest expectation; drive stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (octets_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected octet: expected none actual %02h last %0b",
                         $time, o_data.out_byte, o_data.last_of_item);
            end else begin
                got_due = octets_due.pop_front();
                n_octets++;
                if (o_data.out_byte !== got_due.out_byte) begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, got_due.out_byte, o_data.out_byte);
                end
                if (o_data.last_of_item !== got_due.last_of_item) begin
                    errors++;
                    $display("%0t: last_of_item expected %0b actual %0b",
                             $time, got_due.last_of_item, o_data.last_of_item);
                end
            end
        end
        i_stall <= idle_on && ($urandom_range(99) < 33);
    end

    // Give up after a generous fixed time
    initial begin
        #2000000;
        $display("ber_header_and_oid_encoder_unit: mismatch");
        $finish;
    end

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_data    = '0;
        arcs_seen = 2'd0;
        first_arc = '0;
        idle_on   = 1'b1;
        n_items   = 0;
        n_headers = 0;
        n_arcs    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_arcs_after_reset();
        test_headers();
        test_oid_edges();
        test_random_streams();
        i_valid <= 1'b0;

        // Drain, then keep watching for stray octets
        while (octets_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items (%0d headers, %0d OID arcs), checked %0d octets,",
                 n_items, n_headers, n_arcs, n_octets);
        $display("with random idling and stalls on both sides and %0d errors.", errors);
        if (errors == 0) begin
            $display("ber_header_and_oid_encoder_unit: match");
        end else begin
            $display("ber_header_and_oid_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule
